// ===== hdl/jsu_pkg.sv =====
// Shared types for the JSON string unescaper.
// No dependencies; used by jsu_decode, jsu_burst and json_string_unescaper.
package jsu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 2;   // 0..3 bytes per burst

  // Up to three output bytes produced by one input item
  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic             last;
    logic             err;
  } burst_t;

endpackage

// ===== hdl/jsu_decode.sv =====
// Escape decoder: phase, hex accumulator and drop flag, plus the UTF-8 encoder.
// Depends on jsu_pkg (burst_t).
module jsu_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output jsu_pkg::burst_t       burst
);
  import jsu_pkg::*;

  // plain text, just after a backslash, or waiting for hex digit 1..4
  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_ESC,
    PH_HEX1,
    PH_HEX2,
    PH_HEX3,
    PH_HEX4
  } phase_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  phase_t      phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic        drop_r, drop_nxt;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] code;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_d = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      hex_d = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code = {acc_r, hex_d};

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    drop_nxt   = drop_r;
    burst      = '0;
    burst.last = last_i;
    if (drop_r) begin
      if (last_i) begin
        drop_nxt  = 1'b0;
        phase_nxt = PH_PLAIN;
        acc_nxt   = '0;
      end
    end else if (phase_r == PH_PLAIN) begin
      if (byte_i != CH_BSLASH) begin
        burst.cnt = 2'd1;
        burst.b0  = byte_i;
      end else if (last_i) begin
        burst.err = 1'b1;
      end else begin
        phase_nxt = PH_ESC;
      end
    end else if (phase_r == PH_ESC) begin
      burst.cnt = 2'd1;
      phase_nxt = PH_PLAIN;
      case (byte_i)
        CH_QUOTE:  burst.b0 = 8'h22;
        CH_BSLASH: burst.b0 = 8'h5C;
        CH_SLASH:  burst.b0 = 8'h2F;
        CH_B:      burst.b0 = 8'h08;
        CH_F:      burst.b0 = 8'h0C;
        CH_N:      burst.b0 = 8'h0A;
        CH_R:      burst.b0 = 8'h0D;
        CH_T:      burst.b0 = 8'h09;
        CH_U: begin
          if (last_i) begin
            burst.err = 1'b1;
          end else begin
            burst.cnt = 2'd0;
            phase_nxt = PH_HEX1;
            acc_nxt   = '0;
          end
        end
        default:   burst.err = 1'b1;
      endcase
    end else if (!hex_ok) begin
      burst.err = 1'b1;
    end else if (phase_r >= PH_HEX1 && phase_r < PH_HEX4) begin
      acc_nxt = {acc_r[7:0], hex_d};
      if (last_i) begin
        burst.err = 1'b1;
      end else begin
        phase_nxt = phase_t'(phase_r + 3'd1);
      end
    end else begin
      // fourth digit: encode the code point as it stands
      phase_nxt = PH_PLAIN;
      acc_nxt   = '0;
      if (code < 16'h0080) begin
        burst.cnt = 2'd1;
        burst.b0  = code[7:0];
      end else if (code < 16'h0800) begin
        burst.cnt = 2'd2;
        burst.b0  = 8'hC0 | {3'b000, code[10:6]};
        burst.b1  = 8'h80 | {2'b00, code[5:0]};
      end else begin
        burst.cnt = 2'd3;
        burst.b0  = 8'hE0 | {4'b0000, code[15:12]};
        burst.b1  = 8'h80 | {2'b00, code[11:6]};
        burst.b2  = 8'h80 | {2'b00, code[5:0]};
      end
    end
    // any error: single zero byte marked last, phase reset, drop unless last
    if (burst.err) begin
      burst.cnt  = 2'd1;
      burst.b0   = '0;
      burst.b1   = '0;
      burst.b2   = '0;
      burst.last = 1'b1;
      phase_nxt  = PH_PLAIN;
      acc_nxt    = '0;
      drop_nxt   = !last_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      acc_r   <= '0;
      drop_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// ===== hdl/jsu_burst.sv =====
// Result register: holds one burst of up to three bytes and shifts it out.
// Depends on jsu_pkg (burst_t).
module jsu_burst (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  jsu_pkg::burst_t       burst,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  out_error
);
  import jsu_pkg::*;

  logic [CntW-1:0]  cnt_r;
  logic [ByteW-1:0] b0_r, b1_r, b2_r;
  logic             last_r, err_r;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // free now, or the final byte leaves this cycle
  assign can_load  = (cnt_r == '0) || ((cnt_r == 2'd1) && out_ready);

  assign out_byte  = b0_r;
  assign out_last  = (cnt_r == 2'd1) && last_r;
  assign out_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b0_r   <= burst.b0;
      b1_r   <= burst.b1;
      b2_r   <= burst.b2;
      last_r <= burst.last;
      err_r  <= burst.err;
    end else if (pop) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

endmodule

// ===== hdl/json_string_unescaper.sv =====
// Top level of the JSON string unescaper: input register, decoder, result burst.
// Depends on jsu_pkg, jsu_decode and jsu_burst.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid in_ready in_byte in_last       | in
//  result  | out_valid out_ready out_byte out_last   | out
//          | out_error                               |
//
// One input item per cycle while the result register can take each burst. An
// item is held in the input register until the decoder turns it into a burst
// of zero to three bytes in the result register; the result register drains
// one byte per cycle while out_ready is high, so a \u escape that yields two
// or three UTF-8 bytes holds the input until all but its final byte are taken.
// Synchronous active-low reset clears the escape phase, hex accumulator, drop
// flag and both valid flags. Stalls on out_ready back up into in_ready.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);
  import jsu_pkg::*;

  // input register
  logic       s0_valid_r;
  logic [7:0] s0_byte_r;
  logic       s0_last_r;

  logic   can_load;
  logic   consume;     // item in s0 moves through the decoder this cycle
  burst_t burst;

  assign consume  = s0_valid_r && can_load;
  assign in_ready = !s0_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_byte_r <= in_byte;
      s0_last_r <= in_last;
    end
  end

  jsu_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (consume),
    .byte_i (s0_byte_r),
    .last_i (s0_last_r),
    .burst  (burst)
  );

  jsu_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

  // an error result is always a lone zero byte that closes the string
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_byte == 8'h00))
    else $error("error result not a lone zero byte marked last");

  // an error burst never carries more than one byte
  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    consume && burst.err |-> (burst.cnt == 2'd1))
    else $error("error burst with more than one byte");

  // a full input register is never overwritten while its item is stuck
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !can_load |-> !in_ready)
    else $error("input register accepted over a stalled item");

  // a held multi-byte burst keeps its remaining bytes until taken
  a_burst_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("burst dropped while stalled");

endmodule

// ===== tb/json_string_unescaper_test.sv =====
// Self-checking bench for json_string_unescaper: escaped string bytes in, UTF-8 bytes out.
// Needs only the RTL: the top, its submodules and jsu_pkg; a scoreboard decodes in step.
`timescale 1ns / 100ps

module json_string_unescaper_test;

  // Escape phase of the decoder: plain text, just after a backslash, or one of
  // the four hex digits of a \u escape.
  typedef enum logic [2:0] {
    PH_TEXT,
    PH_ESC,
    PH_HEX1,
    PH_HEX2,
    PH_HEX3,
    PH_HEX4
  } esc_phase_t;

  // One decoded byte as it should leave the result channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } decoded_t;

  // Characters with a meaning inside a JSON string body
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  // Control characters the letter escapes stand for
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};
  localparam logic [15:0] CODE_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                             16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};

  localparam int ITEM_TARGET = 320;
  localparam int TAIL_START  = 270;   // no idling on either side from here on

  // Hex digit value in either case, -1 for anything else
  function automatic int hex_value(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  // Tracks the decoder state and holds the bytes still owed on the result side
  class json_unescape_sb;
    esc_phase_t  phase;
    logic [11:0] accum;
    bit          drop;
    decoded_t    decoded_q[$];
    int          mismatches;

    function new();
      phase      = PH_TEXT;
      accum      = '0;
      drop       = 1'b0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction

    function void owe(logic [7:0] d, logic l, logic e);
      decoded_t r;
      r.data = d;
      r.last = l;
      r.err  = e;
      decoded_q.push_back(r);
    endfunction

    // Malformed escape: one error byte, then drop the rest unless this was the end
    function void malformed(logic l);
      phase = PH_TEXT;
      accum = '0;
      drop  = !l;
      owe(8'h00, 1'b1, 1'b1);
    endfunction

    function void owe_utf8(logic [15:0] code, logic l);
      if (code < 16'h0080) begin
        owe(code[7:0], l, 1'b0);
      end else if (code < 16'h0800) begin
        owe({3'b110, code[10:6]}, 1'b0, 1'b0);
        owe({2'b10, code[5:0]}, l, 1'b0);
      end else begin
        owe({4'b1110, code[15:12]}, 1'b0, 1'b0);
        owe({2'b10, code[11:6]}, 1'b0, 1'b0);
        owe({2'b10, code[5:0]}, l, 1'b0);
      end
    endfunction

    // Called for every accepted input item
    function void accept_raw(logic [7:0] b, logic l);
      int d;
      if (drop) begin
        if (l) begin
          drop  = 1'b0;
          phase = PH_TEXT;
          accum = '0;
        end
        return;
      end
      case (phase)
        PH_TEXT: begin
          if (b != CH_BSLASH) owe(b, l, 1'b0);
          else if (l) malformed(l);
          else phase = PH_ESC;
        end
        PH_ESC: begin
          phase = PH_TEXT;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: owe(b, l, 1'b0);
            CH_B: owe(CTL_BS, l, 1'b0);
            CH_F: owe(CTL_FF, l, 1'b0);
            CH_N: owe(CTL_LF, l, 1'b0);
            CH_R: owe(CTL_CR, l, 1'b0);
            CH_T: owe(CTL_TAB, l, 1'b0);
            CH_U: begin
              if (l) begin
                malformed(l);
              end else begin
                phase = PH_HEX1;
                accum = '0;
              end
            end
            default: malformed(l);
          endcase
        end
        default: begin
          d = hex_value(b);
          if (d < 0) begin
            malformed(l);
          end else if (phase != PH_HEX4) begin
            accum = {accum[7:0], d[3:0]};
            if (l) malformed(l);
            else phase = esc_phase_t'(phase + 3'd1);
          end else begin
            phase = PH_TEXT;
            owe_utf8({accum, d[3:0]}, l);
            accum = '0;
          end
        end
      endcase
    endfunction

    // Called for every accepted result item
    function void match_decoded(logic [7:0] d, logic l, logic e);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result byte=%h last=%b error=%b", $time, d, l, e);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== d) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, d);
        mismatches++;
      end
      if (want.last !== l) begin
        $display("%0t: out_last expected %b actual %b", $time, want.last, l);
        mismatches++;
      end
      if (want.err !== e) begin
        $display("%0t: out_error expected %b actual %b", $time, want.err, e);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  json_unescape_sb sb = new();

  logic [7:0] body[$];   // string body being built, sent as one string
  int         sent = 0;  // input items accepted so far
  bit         calm = 1'b0;
  bit         tail = 1'b0;

  json_string_unescaper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last),
    .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit: far above the slowest legal run (every item stalled on both
  // sides and three results per item still ends well inside this).
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: values sampled at the edge are the pre-edge ones, so the
  // handshake seen here is the one the block sees.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_decoded(out_byte, out_last, out_error);
  end

  // Receiver stalls: short ready/not-ready bursts, now and then a long ready
  // stretch, and no stalls at all once the tail of the run starts.
  initial begin
    forever begin
      if (tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v, logic up);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (up ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Appends \uXXXX; each set bit of upper writes that digit in upper case
  function automatic void add_unicode(logic [15:0] code, logic [3:0] upper);
    body.push_back(CH_BSLASH);
    body.push_back(CH_U);
    for (int i = 3; i >= 0; i--) body.push_back(hex_char(code[4*i +: 4], upper[i]));
  endfunction

  function automatic void add_hex_digits(int n);
    for (int i = 0; i < n; i++) body.push_back(hex_char(4'($urandom), 1'($urandom)));
  endfunction

  // Code points spread over the one, two and three byte encodings plus the edges
  function automatic logic [15:0] rand_code();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: return CODE_EDGES[$urandom_range(0, 7)];
    endcase
  endfunction

  // Appends one token; returns 1 when the token must be the end of the string
  function automatic bit add_token();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_BSLASH) b = ~b;
      body.push_back(b);
    end else if (pick < 60) begin
      body.push_back(CH_BSLASH);
      body.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
    end else if (pick < 90) begin
      add_unicode(rand_code(), 4'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: begin   // unknown escape letter
          do b = 8'($urandom_range(0, 255));
          while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
          body.push_back(CH_BSLASH);
          body.push_back(b);
        end
        1: begin   // non-hex byte somewhere in the four digits
          body.push_back(CH_BSLASH);
          body.push_back(CH_U);
          add_hex_digits($urandom_range(0, 3));
          do b = 8'($urandom_range(0, 255));
          while (hex_value(b) >= 0);
          body.push_back(b);
        end
        2: begin   // backslash as the final byte
          body.push_back(CH_BSLASH);
          return 1'b1;
        end
        default: begin   // string ends before the fourth digit
          body.push_back(CH_BSLASH);
          body.push_back(CH_U);
          add_hex_digits($urandom_range(0, 3));
          return 1'b1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  // One input item; a random idle burst may come first
  task automatic send_byte(logic [7:0] b, logic l);
    if (!tail && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_raw(b, l);
    sent++;
  endtask

  // Sends the built body as one string, last flag on its final byte
  task automatic send_body();
    for (int i = 0; i < body.size(); i++) send_byte(body[i], i == body.size() - 1);
    body.delete();
  endtask

  task automatic directed_strings();
    // byte extremes pass through
    body = '{8'h00, 8'hFF};
    send_body();
    // a letter escape
    body = '{CH_BSLASH, CH_N};
    send_body();
    // largest two-byte code point, mixed-case digits
    add_unicode(16'h07FF, 4'b0101);
    send_body();
    // largest code point, three bytes
    add_unicode(16'hFFFF, 4'b1010);
    send_body();
    // dangling backslash
    body = '{CH_BSLASH};
    send_body();
    // unknown escape, then the rest is dropped up to the last byte
    body = '{CH_BSLASH, 8'h71, 8'h7A};
    send_body();
    // bad hex digit, rest dropped
    body = '{CH_BSLASH, CH_U, 8'h30, 8'h47, 8'h61};
    send_body();
    // string ends inside \u
    body = '{CH_BSLASH, CH_U, 8'h31, 8'h32};
    send_body();
  endtask

  task automatic random_string();
    int n;
    calm = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 6) == 0) begin
      // noise: random bytes with plenty of backslashes
      n = $urandom_range(1, 6);
      repeat (n) body.push_back(($urandom_range(0, 3) == 0) ? CH_BSLASH
                                                            : 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if (add_token()) break;
      end
    end
    send_body();
  endtask

  // Drop valid and hold off until every owed byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_strings();
    drain();

    while (sent < ITEM_TARGET) begin
      if (sent >= TAIL_START) tail = 1'b1;
      random_string();
      if (sent >= ITEM_TARGET / 2 && sent < ITEM_TARGET / 2 + 10) drain();
    end

    drain();
    // keep running so a stray extra result would still be seen
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/jsu_burst.sv
hdl/json_string_unescaper.sv
tb/json_string_unescaper_test.sv
